// ===== hdl/baro_pkg.sv =====
// Shared types, constants and helper functions of the barometer compensation block.
`timescale 1ns / 1ps
`default_nettype none
package baro_pkg;

    localparam int DIV_STAGES = 32;
    localparam int MIDQ_DEPTH = 4;
    localparam int MIDQ_AW    = 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] P_COEF_A   = 32'd3038;
    localparam logic [31:0] P_COEF_B   = 32'hFFFF_E343;
    localparam logic [31:0] P_COEF_C   = 32'd3791;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
    localparam logic [17:0] P_MAX      = 18'h3FFFF;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } coef_t;

    typedef struct packed {
        logic [31:0] b5;
        logic [18:0] up;
        logic        err;
    } mid_item_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/barometer_compensation.sv =====
// Throughput: one request per cycle while full is low; two 32-stage pipelined dividers and the
// arithmetic stages around them set the depth.
// Reset clears all control state and the calibration registers to zero;
// the block accepts requests from the first cycle after reset.
// Top level of the barometer compensation block.
`timescale 1ns / 1ps
`default_nettype none
module barometer_compensation (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [baro_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [15:0]                        raw_temperature,
    input  wire logic [18:0]                        raw_pressure,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [15:0]                      temperature_decidegrees,
    output logic [17:0]                             pressure_pascal,
    output logic                                    math_error
);
    import baro_pkg::*;

    coef_t     coef_reg;
    logic      mid_push;
    logic      mid_pop;
    logic      mid_full;
    logic      mid_empty;
    mid_item_t mid_wr;
    mid_item_t mid_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AC1_AC2:
                begin
                    coef_reg.ac1 <= cfg_data[31:16];
                    coef_reg.ac2 <= cfg_data[15:0];
                end
                CFG_AC3_AC4:
                begin
                    coef_reg.ac3 <= cfg_data[31:16];
                    coef_reg.ac4 <= cfg_data[15:0];
                end
                CFG_AC5_AC6:
                begin
                    coef_reg.ac5 <= cfg_data[31:16];
                    coef_reg.ac6 <= cfg_data[15:0];
                end
                CFG_B1_B2:
                begin
                    coef_reg.b1 <= cfg_data[31:16];
                    coef_reg.b2 <= cfg_data[15:0];
                end
                CFG_MC_MD:
                begin
                    coef_reg.mc <= cfg_data[31:16];
                    coef_reg.md <= cfg_data[15:0];
                end
                CFG_OSS:
                begin
                    coef_reg.oss <= cfg_data[1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    baro_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef            (coef_reg),
        .push            (push),
        .full            (full),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .mid_push        (mid_push),
        .mid_item        (mid_wr),
        .mid_full        (mid_full)
    );

    baro_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_item (mid_wr),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_item (mid_rd),
        .empty   (mid_empty)
    );

    baro_back u_back (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .coef                    (coef_reg),
        .mid_empty               (mid_empty),
        .mid_item                (mid_rd),
        .mid_pop                 (mid_pop),
        .pop                     (pop),
        .empty                   (empty),
        .temperature_decidegrees (temperature_decidegrees),
        .pressure_pascal         (pressure_pascal),
        .math_error              (math_error)
    );

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && math_error) |-> (pressure_pascal == '0 && temperature_decidegrees == '0))
        else $error("error result carries nonzero values");

    a_oss_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == CFG_OSS) |=> (coef_reg.oss == $past(cfg_data[1:0])))
        else $error("oversampling write lost");

    a_mid_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (!(mid_push && mid_full)) && (!(mid_pop && mid_empty)))
        else $error("internal queue overrun or underrun");
`endif

endmodule
`default_nettype wire

// ===== hdl/baro_div.sv =====
// Pipelined unsigned 32-bit divider that resolves one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module baro_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic [31:0]      quotient
);
    import baro_pkg::*;

    logic [31:0] rem_reg [DIV_STAGES];
    logic [31:0] nq_reg  [DIV_STAGES];
    logic [31:0] d_reg   [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic [31:0] rem_in;
        logic [31:0] nq_in;
        logic [31:0] d_in;
        logic [32:0] trial;
        logic        ge;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = dividend;
            assign d_in   = divisor;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign d_in   = d_reg[i-1];
        end

        assign trial = {rem_in, nq_in[31]};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? 32'(trial - {1'b0, d_in}) : trial[31:0];
                nq_reg[i]  <= {nq_in[30:0], ge};
                d_reg[i]   <= d_in;
            end
        end
    end

    assign quotient = nq_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/baro_queue.sv =====
// Four-entry queue that decouples the temperature front end from the pressure back end.
`timescale 1ns / 1ps
`default_nettype none
module baro_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire baro_pkg::mid_item_t   wr_item,
    output logic                       full,
    input  wire logic                  rd_en,
    output baro_pkg::mid_item_t        rd_item,
    output logic                       empty
);
    import baro_pkg::*;

    mid_item_t          mem_reg [MIDQ_DEPTH];
    logic [MIDQ_AW-1:0] wr_ptr_reg;
    logic [MIDQ_AW-1:0] rd_ptr_reg;
    logic [MIDQ_AW:0]   count_reg;
    logic [MIDQ_AW:0]   count_next;

    assign full    = (count_reg == (MIDQ_AW+1)'(MIDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/baro_front.sv =====
// Front end: accepts raw readings and computes the b5 temperature term.
`timescale 1ns / 1ps
`default_nettype none
module baro_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire baro_pkg::coef_t      coef,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [15:0]          raw_temperature,
    input  wire logic [18:0]          raw_pressure,
    output logic                      mid_push,
    output baro_pkg::mid_item_t       mid_item,
    input  wire logic                 mid_full
);
    import baro_pkg::*;

    logic        adv;
    logic [16:0] ut_diff;
    logic [33:0] prod1;
    logic [31:0] x1_c;
    logic [31:0] den_c;
    logic [31:0] num_c;
    logic [31:0] quot;
    logic [31:0] x2_c;

    logic        s1_valid_reg;
    logic [18:0] s1_up_reg;
    logic [31:0] s1_prod_reg;

    logic        s2_valid_reg;
    logic [18:0] s2_up_reg;
    logic [31:0] s2_x1_reg;
    logic [31:0] s2_ma_reg;
    logic [31:0] s2_mb_reg;
    logic        s2_neg_reg;
    logic        s2_err_reg;

    logic        dv_valid_reg [DIV_STAGES];
    logic [18:0] dv_up_reg    [DIV_STAGES];
    logic [31:0] dv_x1_reg    [DIV_STAGES];
    logic        dv_neg_reg   [DIV_STAGES];
    logic        dv_err_reg   [DIV_STAGES];

    assign adv  = !mid_full;
    assign full = mid_full;

    assign ut_diff = {1'b0, raw_temperature} - {1'b0, coef.ac6};
    assign prod1   = 34'($signed(ut_diff) * $signed({1'b0, coef.ac5}));

    assign x1_c  = asr(s1_prod_reg, 5'd15);
    assign den_c = x1_c + sx16(coef.md);
    assign num_c = {{5{coef.mc[15]}}, coef.mc, 11'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= push;
            s2_valid_reg    <= s1_valid_reg;
            dv_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_up_reg   <= raw_pressure;
            s1_prod_reg <= prod1[31:0];
            s2_up_reg   <= s1_up_reg;
            s2_x1_reg   <= x1_c;
            s2_ma_reg   <= num_c[31] ? 32'(0 - num_c) : num_c;
            s2_mb_reg   <= den_c[31] ? 32'(0 - den_c) : den_c;
            s2_neg_reg  <= num_c[31] ^ den_c[31];
            s2_err_reg  <= (den_c == '0);
            dv_up_reg[0]  <= s2_up_reg;
            dv_x1_reg[0]  <= s2_x1_reg;
            dv_neg_reg[0] <= s2_neg_reg;
            dv_err_reg[0] <= s2_err_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_up_reg[i]  <= dv_up_reg[i-1];
                dv_x1_reg[i]  <= dv_x1_reg[i-1];
                dv_neg_reg[i] <= dv_neg_reg[i-1];
                dv_err_reg[i] <= dv_err_reg[i-1];
            end
        end
    end

    baro_div u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (s2_ma_reg),
        .divisor  (s2_mb_reg),
        .quotient (quot)
    );

    assign x2_c         = dv_neg_reg[DIV_STAGES-1] ? 32'(0 - quot) : quot;
    assign mid_push     = adv && dv_valid_reg[DIV_STAGES-1];
    assign mid_item.b5  = dv_x1_reg[DIV_STAGES-1] + x2_c;
    assign mid_item.up  = dv_up_reg[DIV_STAGES-1];
    assign mid_item.err = dv_err_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/baro_back.sv =====
// Back end: computes the temperature, the pressure terms, the final pressure and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module baro_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire baro_pkg::coef_t      coef,
    input  wire logic                 mid_empty,
    input  wire baro_pkg::mid_item_t  mid_item,
    output logic                      mid_pop,
    input  wire logic                 pop,
    output logic                      empty,
    output logic signed [15:0]        temperature_decidegrees,
    output logic [17:0]               pressure_pascal,
    output logic                      math_error
);
    import baro_pkg::*;

    typedef struct packed {
        logic [15:0] t;
        logic [17:0] p;
        logic        err;
    } out_item_t;

    logic        adv;
    logic [31:0] tv_c;
    logic [15:0] t_c;
    logic [31:0] x3_c;
    logic [31:0] b3_c;
    logic [31:0] x3b_c;
    logic [31:0] b4_c;
    logic [31:0] p_c;
    logic [31:0] sh_c;
    logic [31:0] fp_c;
    logic [17:0] pr_c;
    logic [31:0] quot;

    logic        v_reg [9];
    logic [15:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg, t8_reg;
    logic        e0_reg, e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, e6_reg, e7_reg, e8_reg;
    logic [18:0] up0_reg, up1_reg, up2_reg, up3_reg, up4_reg;
    logic [31:0] b6_reg;
    logic [31:0] p66_reg, pac2_reg, pac3_reg;
    logic [31:0] sq_reg, x2a2_reg, x1c2_reg;
    logic [31:0] m1_reg, m2_reg, x2a3_reg, x1c3_reg;
    logic [31:0] b3_reg, x3b_reg;
    logic [31:0] p4_reg, b7_reg;
    logic [31:0] n_reg, d_reg;
    logic        fl_reg;
    logic [31:0] p7_reg, pa_reg, pb_reg;
    logic [31:0] p8_reg, m3_reg, x2_reg;

    logic        dv_valid_reg [DIV_STAGES];
    logic [15:0] dv_t_reg     [DIV_STAGES];
    logic        dv_err_reg   [DIV_STAGES];
    logic        dv_fl_reg    [DIV_STAGES];

    out_item_t   oq_reg [2];
    logic        oq_wr_reg;
    logic        oq_rd_reg;
    logic [1:0]  oq_count_reg;
    logic        oq_full;
    logic        oq_push;
    logic        oq_pop;
    out_item_t   oq_in;

    assign oq_full = (oq_count_reg == 2'd2);
    assign adv     = !oq_full;
    assign mid_pop = adv && !mid_empty;

    assign tv_c = asr(mid_item.b5 + 32'd8, 5'd4);
    always_comb
    begin
        if ($signed(tv_c) > 32'sd32767)
        begin
            t_c = 16'h7FFF;
        end
        else if ($signed(tv_c) < -32'sd32768)
        begin
            t_c = 16'h8000;
        end
        else
        begin
            t_c = tv_c[15:0];
        end
    end

    assign x3_c  = asr(m1_reg, 5'd11) + x2a3_reg;
    assign b3_c  = asr(32'(((sx16(coef.ac1) << 2) + x3_c) << coef.oss) + 32'd2, 5'd2);
    assign x3b_c = asr(x1c3_reg + asr(m2_reg, 5'd16) + 32'd2, 5'd2);
    assign b4_c  = p4_reg >> 15;

    assign p_c  = dv_fl_reg[DIV_STAGES-1] ? {quot[30:0], 1'b0} : quot;
    assign sh_c = asr(p_c, 5'd8);

    assign fp_c = p8_reg + asr(asr(m3_reg, 5'd16) + x2_reg + P_COEF_C, 5'd4);
    always_comb
    begin
        if (fp_c[31])
        begin
            pr_c = '0;
        end
        else if (fp_c > {14'b0, P_MAX})
        begin
            pr_c = P_MAX;
        end
        else
        begin
            pr_c = fp_c[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= mid_pop;
            for (int i = 1; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            dv_valid_reg[0] <= v_reg[6];
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            v_reg[7] <= dv_valid_reg[DIV_STAGES-1];
            v_reg[8] <= v_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg   <= t_c;
            e0_reg   <= mid_item.err;
            up0_reg  <= mid_item.up;
            b6_reg   <= mid_item.b5 - B6_OFFSET;

            t1_reg   <= t0_reg;
            e1_reg   <= e0_reg;
            up1_reg  <= up0_reg;
            p66_reg  <= 32'(b6_reg * b6_reg);
            pac2_reg <= 32'(sx16(coef.ac2) * b6_reg);
            pac3_reg <= 32'(sx16(coef.ac3) * b6_reg);

            t2_reg   <= t1_reg;
            e2_reg   <= e1_reg;
            up2_reg  <= up1_reg;
            sq_reg   <= asr(p66_reg, 5'd12);
            x2a2_reg <= asr(pac2_reg, 5'd11);
            x1c2_reg <= asr(pac3_reg, 5'd13);

            t3_reg   <= t2_reg;
            e3_reg   <= e2_reg;
            up3_reg  <= up2_reg;
            m1_reg   <= 32'(sx16(coef.b2) * sq_reg);
            m2_reg   <= 32'(sx16(coef.b1) * sq_reg);
            x2a3_reg <= x2a2_reg;
            x1c3_reg <= x1c2_reg;

            t4_reg   <= t3_reg;
            e4_reg   <= e3_reg;
            up4_reg  <= up3_reg;
            b3_reg   <= b3_c;
            x3b_reg  <= x3b_c;

            t5_reg   <= t4_reg;
            e5_reg   <= e4_reg;
            p4_reg   <= 32'({16'b0, coef.ac4} * (x3b_reg + B4_BIAS));
            b7_reg   <= 32'(({13'b0, up4_reg} - b3_reg) * (B7_SCALE >> coef.oss));

            t6_reg   <= t5_reg;
            e6_reg   <= e5_reg | (b4_c == '0);
            fl_reg   <= b7_reg[31];
            n_reg    <= b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
            d_reg    <= b4_c;

            dv_t_reg[0]   <= t6_reg;
            dv_err_reg[0] <= e6_reg;
            dv_fl_reg[0]  <= fl_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_t_reg[i]   <= dv_t_reg[i-1];
                dv_err_reg[i] <= dv_err_reg[i-1];
                dv_fl_reg[i]  <= dv_fl_reg[i-1];
            end

            t7_reg   <= dv_t_reg[DIV_STAGES-1];
            e7_reg   <= dv_err_reg[DIV_STAGES-1];
            p7_reg   <= p_c;
            pa_reg   <= 32'(sh_c * sh_c);
            pb_reg   <= 32'(P_COEF_B * p_c);

            t8_reg   <= t7_reg;
            e8_reg   <= e7_reg;
            p8_reg   <= p7_reg;
            m3_reg   <= 32'(pa_reg * P_COEF_A);
            x2_reg   <= asr(pb_reg, 5'd16);
        end
    end

    baro_div u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (n_reg),
        .divisor  (d_reg),
        .quotient (quot)
    );

    assign oq_push   = adv && v_reg[8];
    assign oq_pop    = pop && !empty;
    assign oq_in.t   = e8_reg ? 16'd0 : t8_reg;
    assign oq_in.p   = e8_reg ? 18'd0 : pr_c;
    assign oq_in.err = e8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (oq_push && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + 2'd1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_count_reg <= oq_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= oq_in;
        end
    end

    assign empty                   = (oq_count_reg == '0);
    assign temperature_decidegrees = $signed(oq_reg[oq_rd_reg].t);
    assign pressure_pascal         = oq_reg[oq_rd_reg].p;
    assign math_error              = oq_reg[oq_rd_reg].err;

endmodule
`default_nettype wire
